// ===== rtl/core/bdac_pkg.sv =====
// Shared types and constants for the button debounce, auto-repeat and click block.
package bdac_pkg;

  localparam int unsigned CFG_BITS = 16;
  localparam int unsigned NUM_DIRS = 4;

  localparam logic [CFG_BITS-1:0] DEBOUNCE_RESET        = CFG_BITS'(85);
  localparam logic [CFG_BITS-1:0] REPEAT_DELAY_RESET    = CFG_BITS'(500);
  localparam logic [CFG_BITS-1:0] REPEAT_INTERVAL_RESET = CFG_BITS'(200);
  localparam logic [CFG_BITS-1:0] CLICK_WINDOW_RESET    = CFG_BITS'(500);

  typedef enum logic [1:0] {
    REG_DEBOUNCE        = 2'd0,
    REG_REPEAT_DELAY    = 2'd1,
    REG_REPEAT_INTERVAL = 2'd2,
    REG_CLICK_WINDOW    = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    MENU_NONE   = 2'd0,
    MENU_SINGLE = 2'd1,
    MENU_LONG   = 2'd2,
    MENU_DOUBLE = 2'd3
  } menu_event_t;

  typedef struct packed {
    logic [CFG_BITS-1:0] debounce_ms;
    logic [CFG_BITS-1:0] repeat_delay_ms;
    logic [CFG_BITS-1:0] repeat_interval_ms;
    logic [CFG_BITS-1:0] click_window_ms;
  } cfg_t;

  typedef struct packed {
    logic up_level;
    logic down_level;
    logic left_level;
    logic right_level;
    logic menu_level;
  } in_word_t;

  typedef struct packed {
    logic       up_step;
    logic       down_step;
    logic       left_step;
    logic       right_step;
    logic [1:0] menu_event;
  } out_word_t;

endpackage

// ===== rtl/core/bdac_regs.sv =====
// Configuration register file behind the APB-style port.
module bdac_regs
  import bdac_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic       wr_en;
  reg_index_t wr_index;

  assign pready   = 1'b1;
  assign wr_en    = psel && penable && pwrite;
  assign wr_index = reg_index_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms        <= DEBOUNCE_RESET;
      cfg.repeat_delay_ms    <= REPEAT_DELAY_RESET;
      cfg.repeat_interval_ms <= REPEAT_INTERVAL_RESET;
      cfg.click_window_ms    <= CLICK_WINDOW_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_DEBOUNCE:        cfg.debounce_ms        <= pwdata[CFG_BITS-1:0];
        REG_REPEAT_DELAY:    cfg.repeat_delay_ms    <= pwdata[CFG_BITS-1:0];
        REG_REPEAT_INTERVAL: cfg.repeat_interval_ms <= pwdata[CFG_BITS-1:0];
        REG_CLICK_WINDOW:    cfg.click_window_ms    <= pwdata[CFG_BITS-1:0];
        default:             cfg.debounce_ms        <= cfg.debounce_ms;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (wr_index)
      REG_DEBOUNCE:        prdata[CFG_BITS-1:0] = cfg.debounce_ms;
      REG_REPEAT_DELAY:    prdata[CFG_BITS-1:0] = cfg.repeat_delay_ms;
      REG_REPEAT_INTERVAL: prdata[CFG_BITS-1:0] = cfg.repeat_interval_ms;
      REG_CLICK_WINDOW:    prdata[CFG_BITS-1:0] = cfg.click_window_ms;
      default:             prdata = '0;
    endcase
  end

  a_debounce_write: assert property (@(posedge clk) disable iff (rst)
    wr_en && wr_index == REG_DEBOUNCE |=> cfg.debounce_ms == $past(pwdata[CFG_BITS-1:0]))
    else $error("debounce register did not take the written word");

endmodule

// ===== rtl/core/bdac_dir_chan.sv =====
// One direction button: level age, repeat age, held flag and step pulse.
module bdac_dir_chan
  import bdac_pkg::*;
#(
  parameter int unsigned AGE_BITS = 16
)
(
  input  logic clk,
  input  logic rst,
  input  logic advance,
  input  logic level,
  input  cfg_t cfg,
  output logic step
);

  localparam int unsigned CMP_W = (AGE_BITS > CFG_BITS) ? AGE_BITS : CFG_BITS;

  logic                prev_level;
  logic [AGE_BITS-1:0] edge_age;
  logic [AGE_BITS-1:0] repeat_age;
  logic                held;

  logic [AGE_BITS-1:0] edge_age_next;
  logic [AGE_BITS-1:0] repeat_inc;
  logic [AGE_BITS-1:0] repeat_age_next;
  logic                held_kept;
  logic                held_next;
  logic                qualified;
  logic                first_press;
  logic                repeat_pulse;

  always_comb begin
    edge_age_next = (level != prev_level) ? '0 :
                    ((&edge_age) ? edge_age : edge_age + 1'b1);
    repeat_inc    = (&repeat_age) ? repeat_age : repeat_age + 1'b1;
    held_kept     = held && level;
    qualified     = level && (CMP_W'(edge_age_next) > CMP_W'(cfg.debounce_ms));
    first_press   = qualified && !held_kept;
    repeat_pulse  = qualified
                    && (CMP_W'(edge_age_next) > CMP_W'(cfg.repeat_delay_ms))
                    && (CMP_W'(repeat_inc) > CMP_W'(cfg.repeat_interval_ms));
    step            = first_press || repeat_pulse;
    held_next       = held_kept || first_press;
    repeat_age_next = repeat_pulse ? '0 : repeat_inc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_level <= 1'b0;
      edge_age   <= '0;
      repeat_age <= '0;
      held       <= 1'b0;
    end else if (advance) begin
      prev_level <= level;
      edge_age   <= edge_age_next;
      repeat_age <= repeat_age_next;
      held       <= held_next;
    end
  end

  a_step_sets_held: assert property (@(posedge clk) disable iff (rst)
    advance && step |=> held)
    else $error("step pulse given without the held flag being set");

endmodule

// ===== rtl/core/bdac_menu.sv =====
// Menu button: press counting and click classification after the quiet window.
module bdac_menu
  import bdac_pkg::*;
#(
  parameter int unsigned AGE_BITS = 16
)
(
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  logic        level,
  input  cfg_t        cfg,
  output menu_event_t menu_event
);

  localparam int unsigned CMP_W = (AGE_BITS > CFG_BITS) ? AGE_BITS : CFG_BITS;

  logic                prev_level;
  logic [AGE_BITS-1:0] edge_age;
  logic                held;
  logic [1:0]          press_count;

  logic [AGE_BITS-1:0] edge_age_next;
  logic                held_kept;
  logic                press;
  logic [1:0]          count_inc;
  logic                window_over;
  logic [1:0]          press_count_next;
  logic                held_next;

  always_comb begin
    edge_age_next = (level != prev_level) ? '0 :
                    ((&edge_age) ? edge_age : edge_age + 1'b1);
    held_kept   = held && level;
    press       = level && (CMP_W'(edge_age_next) > CMP_W'(cfg.debounce_ms)) && !held_kept;
    count_inc   = (press && press_count != 2'd3) ? press_count + 2'd1 : press_count;
    held_next   = held_kept || press;
    window_over = CMP_W'(edge_age_next) > CMP_W'(cfg.click_window_ms);

    menu_event       = MENU_NONE;
    press_count_next = count_inc;
    if (window_over) begin
      press_count_next = 2'd0;
      if (count_inc == 2'd1) begin
        menu_event = level ? MENU_LONG : MENU_SINGLE;
      end else if (count_inc == 2'd2 && !level) begin
        menu_event = MENU_DOUBLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_level  <= 1'b0;
      edge_age    <= '0;
      held        <= 1'b0;
      press_count <= 2'd0;
    end else if (advance) begin
      prev_level  <= level;
      edge_age    <= edge_age_next;
      held        <= held_next;
      press_count <= press_count_next;
    end
  end

  a_event_clears_count: assert property (@(posedge clk) disable iff (rst)
    advance && menu_event != MENU_NONE |=> press_count == 2'd0)
    else $error("press count not cleared after a menu event");

endmodule

// ===== rtl/core/button_debounce_autorepeat_click.sv =====
// Top level of the button debounce, auto-repeat and menu click block.
//
//   Channel  Direction  Handshake                  Word
//   item     in         item_valid / item_ready    in_word_t: five raw button levels
//   result   out        result_valid / result_ready out_word_t: four steps, menu event
//   config   in         psel, penable, pwrite      APB-style, four 16-bit registers
//
// Each accepted word is one millisecond tick. It is first captured in an input
// register; when the result register can load, the per-button logic updates its
// ages and flags and the outcome is written to the result register, which raises
// result_valid. One word is taken every cycle while the result side keeps up, so
// the sustained rate is one word per cycle.
// Reset (rst, synchronous) clears both pipeline stages, all ages, held flags and
// the press count, and loads the register defaults. When result_valid is high and
// result_ready low, the result register and a full input register hold; an empty
// input register still takes one further word before item_ready falls.
module button_debounce_autorepeat_click
  import bdac_pkg::*;
#(
  parameter int unsigned AGE_BITS = 16
)
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  in_word_t    item,
  output logic        result_valid,
  input  logic        result_ready,
  output out_word_t   result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t cfg;

  // Input register stage.
  logic     s1_valid;
  in_word_t s1_word;

  // Pipeline control: the result register loads when it is empty or being read.
  logic out_load;
  logic s1_adv;

  logic [NUM_DIRS-1:0] dir_levels;
  logic [NUM_DIRS-1:0] dir_steps;
  menu_event_t         menu_ev;
  out_word_t           result_next;

  assign out_load   = !result_valid || result_ready;
  assign s1_adv     = s1_valid && out_load;
  assign item_ready = !s1_valid || out_load;

  bdac_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Direction order matches the step bits: up, down, left, right.
  assign dir_levels = {s1_word.up_level, s1_word.down_level,
                       s1_word.left_level, s1_word.right_level};

  for (genvar g = 0; g < NUM_DIRS; g++) begin : g_dir
    bdac_dir_chan #(
      .AGE_BITS (AGE_BITS)
    ) u_dir (
      .clk     (clk),
      .rst     (rst),
      .advance (s1_adv),
      .level   (dir_levels[g]),
      .cfg     (cfg),
      .step    (dir_steps[g])
    );
  end

  bdac_menu #(
    .AGE_BITS (AGE_BITS)
  ) u_menu (
    .clk        (clk),
    .rst        (rst),
    .advance    (s1_adv),
    .level      (s1_word.menu_level),
    .cfg        (cfg),
    .menu_event (menu_ev)
  );

  always_comb begin
    result_next.up_step    = dir_steps[3];
    result_next.down_step  = dir_steps[2];
    result_next.left_step  = dir_steps[1];
    result_next.right_step = dir_steps[0];
    result_next.menu_event = menu_ev;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (item_ready) begin
        s1_valid <= item_valid;
      end
      if (out_load) begin
        result_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      s1_word <= item;
    end
    if (s1_adv) begin
      result <= result_next;
    end
  end

  // A word waiting in the input register while the result side stalls must
  // neither move on nor change.
  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_load |=> s1_valid && $stable(s1_word))
    else $error("input register lost or changed a stalled word");

endmodule

// ===== verif/tb_button_debounce_autorepeat_click.sv =====
// Self-checking testbench for the button debounce, auto-repeat and menu click block.
module tb_button_debounce_autorepeat_click;
  timeunit 1ns;
  timeprecision 1ps;
  import bdac_pkg::*;

  // Ages in the block are AGE_BITS wide; the instance keeps the default width.
  localparam int unsigned AGE_BITS = 16;
  localparam int unsigned CYCLE_LIMIT = 100_000;

  // Button masks in the bit order of the input word: up is the top bit, menu the bottom one.
  localparam logic [4:0] UP = 5'b10000;
  localparam logic [4:0] DOWN = 5'b01000;
  localparam logic [4:0] LEFT = 5'b00100;
  localparam logic [4:0] RIGHT = 5'b00010;
  localparam logic [4:0] MENU = 5'b00001;
  localparam logic [4:0] NONE = 5'b00000;
  localparam logic [4:0] ALL = 5'b11111;
  localparam int MENU_BIT = 0;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  in_word_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  out_word_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  button_debounce_autorepeat_click dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #10 clk = ~clk;

  // Our own copy of the block's state. Ages are indexed by the bit position of the button
  // in the input word, so the menu age sits at index 0 and the direction ages at 4 down to 1.
  cfg_t setting = '{DEBOUNCE_RESET, REPEAT_DELAY_RESET, REPEAT_INTERVAL_RESET,
                    CLICK_WINDOW_RESET};
  logic [4:0] prior_levels = '0;
  logic [AGE_BITS-1:0] level_age [4:0] = '{default: '0};
  logic [AGE_BITS-1:0] pulse_age [4:1] = '{default: '0};
  logic [4:0] reported = '0;
  logic [1:0] menu_presses = '0;

  // Outcomes still owed by the block, oldest first.
  out_word_t outcome_due [$];

  // When steady is set neither side idles, which gives long stretches at full rate.
  bit steady = 1'b0;
  int unsigned errors = 0;
  int unsigned ticks_sent = 0;
  int unsigned outcomes_checked = 0;
  int unsigned settings_applied = 0;
  int unsigned cycle_count = 0;

  // State of the random press generator: current level and ticks left before it flips.
  logic [4:0] gen_levels = '0;
  int gen_left [4:0] = '{default: 0};

  function automatic logic [AGE_BITS-1:0] age_inc(logic [AGE_BITS-1:0] a);
    return (a == '1) ? a : a + 1'b1;
  endfunction

  // Advances our copy of the block by one millisecond tick and returns the word it owes.
  function automatic out_word_t advance_tick(in_word_t w);
    logic [4:0] lv;
    logic [3:0] steps;
    menu_event_t ev;
    lv = w;
    steps = '0;
    ev = MENU_NONE;
    // All ages move first: a level change restarts the age, otherwise it creeps up and
    // sticks at its ceiling. A released button may report again on its next press.
    for (int b = 0; b < 5; b++) begin
      level_age[b] = (lv[b] != prior_levels[b]) ? '0 : age_inc(level_age[b]);
      if (!lv[b]) reported[b] = 1'b0;
    end
    for (int b = 1; b < 5; b++) pulse_age[b] = age_inc(pulse_age[b]);
    prior_levels = lv;
    // A direction gives one step when it first qualifies, then repeats while held. A press
    // and a repeat falling on the same tick still make a single step.
    for (int b = 1; b < 5; b++) begin
      if (lv[b] && level_age[b] > setting.debounce_ms) begin
        if (!reported[b]) begin
          steps[b-1] = 1'b1;
          reported[b] = 1'b1;
        end
        if (level_age[b] > setting.repeat_delay_ms &&
            pulse_age[b] > setting.repeat_interval_ms) begin
          steps[b-1] = 1'b1;
          pulse_age[b] = '0;
        end
      end
    end
    // Menu presses are counted, saturating at three.
    if (lv[MENU_BIT] && level_age[MENU_BIT] > setting.debounce_ms && !reported[MENU_BIT]) begin
      if (menu_presses != 2'd3) menu_presses = menu_presses + 2'd1;
      reported[MENU_BIT] = 1'b1;
    end
    // Once the menu has been quiet long enough the count is classified and cleared, even
    // when the press was only counted on this very tick.
    if (level_age[MENU_BIT] > setting.click_window_ms) begin
      if (menu_presses == 2'd1) ev = lv[MENU_BIT] ? MENU_LONG : MENU_SINGLE;
      else if (menu_presses == 2'd2 && !lv[MENU_BIT]) ev = MENU_DOUBLE;
      menu_presses = '0;
    end
    return out_word_t'({steps, ev});
  endfunction

  // Sends one word of button levels. The sender may first idle for a random gap; valid
  // is only lowered when a gap really follows, so back-to-back words keep it high.
  task automatic send_levels(logic [4:0] levels);
    int gap;
    gap = 0;
    if (!steady) begin
      while (gap < 6 && $urandom_range(99) < 35) gap++;
    end
    @(negedge clk);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid <= 1'b1;
    item <= in_word_t'(levels);
    do @(posedge clk); while (!item_ready);
    outcome_due.push_back(advance_tick(in_word_t'(levels)));
    ticks_sent++;
  endtask

  task automatic hold_levels(logic [4:0] levels, int ticks);
    repeat (ticks) send_levels(levels);
  endtask

  // Stops the sender and waits until the block has handed back every word it owes.
  task automatic let_results_drain();
    @(negedge clk);
    item_valid <= 1'b0;
    while (outcome_due.size() != 0) @(posedge clk);
  endtask

  // One register write: a setup phase, then an access phase that completes on pready.
  task automatic write_setting(reg_index_t idx, logic [CFG_BITS-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'h0000, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_DEBOUNCE: setting.debounce_ms = value;
      REG_REPEAT_DELAY: setting.repeat_delay_ms = value;
      REG_REPEAT_INTERVAL: setting.repeat_interval_ms = value;
      REG_CLICK_WINDOW: setting.click_window_ms = value;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apply_settings(cfg_t s);
    write_setting(REG_DEBOUNCE, s.debounce_ms);
    write_setting(REG_REPEAT_DELAY, s.repeat_delay_ms);
    write_setting(REG_REPEAT_INTERVAL, s.repeat_interval_ms);
    write_setting(REG_CLICK_WINDOW, s.click_window_ms);
    settings_applied++;
  endtask

  // Picks how long a button keeps its new level. Half of the holds land just either side of a
  // threshold of the current setting, some are contact bounce and some are plain random.
  function automatic int pick_hold(int b);
    int base;
    case ($urandom_range(5))
      0: return $urandom_range(3, 1);
      1: base = setting.debounce_ms;
      2: base = (b == MENU_BIT) ? setting.click_window_ms : setting.repeat_delay_ms;
      3: base = setting.repeat_delay_ms + 2 * setting.repeat_interval_ms;
      default: return $urandom_range(40, 1);
    endcase
    if (base > 200) base = $urandom_range(200, 20);
    base = base + $urandom_range(3) - 1;
    return (base < 1) ? 1 : base;
  endfunction

  // Press patterns with random timing; roughly one word in eight is pure noise instead.
  task automatic random_ticks(int count);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(99) < 12) begin
        send_levels(5'($urandom_range(31)));
      end else begin
        for (int b = 0; b < 5; b++) begin
          if (gen_left[b] <= 0) begin
            gen_levels[b] = ~gen_levels[b];
            gen_left[b] = pick_hold(b);
          end
          gen_left[b]--;
        end
        send_levels(gen_levels);
      end
    end
  endtask

  // The receiver stalls at random except during steady stretches.
  always @(negedge clk) begin
    result_ready <= steady || ($urandom_range(99) >= 35);
  end

  task automatic check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  // Every accepted result word is compared with the oldest outcome still owed.
  always @(posedge clk) begin : result_check
    out_word_t want;
    if (!rst && result_valid && result_ready) begin
      if (outcome_due.size() == 0) begin
        errors++;
        $display("%0t ns: result word %b arrived with nothing owed, expected none",
                 $time, result);
      end else begin
        want = outcome_due.pop_front();
        check_field("up_step", want.up_step, result.up_step);
        check_field("down_step", want.down_step, result.down_step);
        check_field("left_step", want.left_step, result.left_step);
        check_field("right_step", want.right_step, result.right_step);
        check_field("menu_event", want.menu_event, result.menu_event);
        outcomes_checked++;
      end
    end
  end

  // Guards against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t ns: run still busy after %0d cycles", $time, CYCLE_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  // Reset defaults: brief levels of every kind, far too short for anything to qualify.
  task automatic test_reset_state();
    hold_levels(NONE, 1);
    hold_levels(ALL, 2);
    hold_levels(NONE, 1);
    hold_levels(UP, 1);
    hold_levels(DOWN, 1);
    hold_levels(LEFT, 1);
    hold_levels(RIGHT, 1);
    hold_levels(MENU, 1);
  endtask

  // Still on the defaults: up held long enough for a press and two repeats, and a menu
  // press released well inside the run so that a single click is reported. The long
  // hold runs with neither side idling.
  task automatic test_default_timing();
    hold_levels(UP | MENU, 120);
    steady = 1'b1;
    hold_levels(UP, 640);
    steady = 1'b0;
    hold_levels(NONE, 2);
    let_results_drain();
  endtask

  // Every register at zero: a level qualifies on its second stable tick.
  task automatic test_zero_settings();
    apply_settings('0);
    hold_levels(ALL, 3);
    hold_levels(NONE, 2);
    hold_levels(MENU, 2);
    hold_levels(NONE, 2);
    let_results_drain();
  endtask

  // The first press and a repeat fall on the same tick, and a menu press is counted and
  // classified as a long press on one tick because the window is shorter than debounce.
  task automatic test_coinciding_pulses();
    apply_settings('{16'd3, 16'd0, 16'd0, 16'd1});
    hold_levels(UP | MENU, 6);
    hold_levels(NONE, 3);
    let_results_drain();
  endtask

  // Single, double and triple clicks, then a long press with right repeating alongside.
  task automatic test_click_patterns();
    apply_settings('{16'd0, 16'd3, 16'd1, 16'd2});
    hold_levels(MENU, 2);
    hold_levels(NONE, 4);
    repeat (2) begin
      hold_levels(MENU, 2);
      hold_levels(NONE, 1);
    end
    hold_levels(NONE, 3);
    repeat (3) begin
      hold_levels(MENU, 2);
      hold_levels(NONE, 1);
    end
    hold_levels(NONE, 3);
    hold_levels(MENU | RIGHT, 6);
    hold_levels(NONE, 4);
    let_results_drain();
  endtask

  // Random press traffic under several settings, the all-zero and all-ones ones among
  // them. Halfway through each setting the sender waits until every word is back.
  task automatic test_random_traffic();
    cfg_t s;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        1: s = '0;
        3: s = '1;
        default: begin
          s.debounce_ms = $urandom_range(6);
          s.repeat_delay_ms = $urandom_range(15);
          s.repeat_interval_ms = $urandom_range(5);
          s.click_window_ms = $urandom_range(12);
        end
      endcase
      let_results_drain();
      apply_settings(s);
      steady = (phase == 2);
      random_ticks(35);
      let_results_drain();
      random_ticks(35);
      steady = 1'b0;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_default_timing();
    test_zero_settings();
    test_coinciding_pulses();
    test_click_patterns();
    test_random_traffic();

    let_results_drain();
    repeat (8) @(posedge clk);
    $display("Sent %0d ticks over %0d register settings, with presses, repeats and clicks,",
             ticks_sent, settings_applied);
    $display("and checked %0d result words with %0d mismatches.", outcomes_checked, errors);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
